@@ design/assert_macros.svh @@
// Assertion helpers used by the top-level file to check internal behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, idle in reset.
`define AST_IMPL(name, a, b) name: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (b)) else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock, idle in reset.
`define AST_NEXT(name, a, b) name: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (b)) else $error("next-cycle check failed");

`endif

@@ design/htsd_pkg.sv @@
package htsd_pkg;

    localparam int NODES            = 512;
    localparam int MAX_SYMBOL_BYTES = 8;
    localparam int STACK_DEPTH      = NODES + 1;

    localparam int NODE_W   = $clog2(NODES);
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W    = $clog2(MAX_SYMBOL_BYTES + 1);
    localparam int STORE_AW = $clog2(NODES * MAX_SYMBOL_BYTES);
    localparam int ENT_W    = NODE_W + 1;

    localparam logic [23:0] TAG_ABL = 24'h41424C;
    localparam logic [23:0] TAG_HMT = 24'h484D54;
    localparam logic [23:0] TAG_REM = 24'h52454D;
    localparam logic [23:0] TAG_DAT = 24'h444154;

    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_BAD_CODE = 3'd1;
    localparam logic [2:0] ST_TREE_ERR = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_DEFAULT  = 3'd4;

    typedef enum logic [2:0] {
        TK_ABL,
        TK_HMT,
        TK_REM,
        TK_DAT,
        TK_OTHER
    } tag_kind_t;

    typedef struct packed {
        logic       load;
        logic       tag_first;
        logic       tag_shift;
        logic       set_len;
        logic       len_default;
        logic       set_drop;
        logic       drop_default;
        logic       tree_start;
        logic       set_leaf;
        logic       set_inner;
        logic       push;
        logic       push_side;
        logic       pop_rd;
        logic       new_node;
        logic       link;
        logic       sp_clear;
        logic       sym_write;
        logic       idx_inc;
        logic       idx_clear;
        logic       bit_clear;
        logic       bit_next;
        logic       node_rd;
        logic       walk_step;
        logic       walk_root;
        logic       sym_rd;
        logic       emit;
        logic       emit_data;
        logic [2:0] emit_code;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        tag_kind_t tag_kind;
        logic      byte_zero;
        logic      byte_b0;
        logic      byte_b1;
        logic      len_over;
        logic      byte_ws;
        logic      len_set;
        logic      drop_set;
        logic      len_zero;
        logic      sym_done;
        logic      sp_zero;
        logic      sp_full;
        logic      count_full;
        logic      bits_done;
        logic      nxt_none;
        logic      leaf;
        logic      leaf_done;
        logic      out_free;
        logic      pend_valid;
    } sts_t;

endpackage

@@ design/htsd_dp.sv @@
module htsd_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  htsd_pkg::cmd_t   cmd,
    output htsd_pkg::sts_t   sts,
    input  logic [7:0]       in_byte,
    input  logic             final_byte,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             symbol_end,
    output logic             run_last,
    output logic [2:0]       status
);

    logic [7:0]                      byte_reg;
    logic                            last_reg;
    logic [15:0]                     tag_reg;
    logic [htsd_pkg::IDX_W-1:0]      len_reg;
    logic                            len_set_reg;
    logic [7:0]                      drop_reg;
    logic                            drop_set_reg;
    logic                            tree_valid_reg;
    logic [htsd_pkg::CNT_W-1:0]      node_count_reg;
    logic [htsd_pkg::NODE_W-1:0]     build_reg;
    logic [htsd_pkg::SP_W-1:0]       sp_reg;
    logic [htsd_pkg::NODE_W-1:0]     walk_reg;
    logic [3:0]                      bit_reg;
    logic [htsd_pkg::IDX_W-1:0]      idx_reg;

    logic [htsd_pkg::NODE_W-1:0] left_mem   [0:htsd_pkg::NODES-1];
    logic [htsd_pkg::NODE_W-1:0] right_mem  [0:htsd_pkg::NODES-1];
    logic [htsd_pkg::IDX_W-1:0]  nbytes_mem [0:htsd_pkg::NODES-1];
    logic [7:0]                  store_mem  [0:htsd_pkg::NODES*htsd_pkg::MAX_SYMBOL_BYTES-1];
    logic [htsd_pkg::ENT_W-1:0]  stack_mem  [0:htsd_pkg::STACK_DEPTH-1];

    logic [htsd_pkg::NODE_W-1:0] left_q;
    logic [htsd_pkg::NODE_W-1:0] right_q;
    logic [htsd_pkg::IDX_W-1:0]  nbytes_q;
    logic [7:0]                  store_q;
    logic [htsd_pkg::ENT_W-1:0]  stack_q;

    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic       pend_end_reg;
    logic [2:0] pend_status_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       out_last_reg;
    logic [2:0] out_status_reg;

    logic [23:0]                 tag_full;
    logic [3:0]                  nbits;
    logic                        bit_val;
    logic [htsd_pkg::NODE_W-1:0] nxt;
    logic [htsd_pkg::IDX_W-1:0]  cnt;
    logic [htsd_pkg::NODE_W-1:0] parent;
    logic                        side;
    logic                        out_free;
    logic [htsd_pkg::STORE_AW-1:0] wr_addr;
    logic [htsd_pkg::STORE_AW-1:0] rd_addr;
    logic [htsd_pkg::NODE_W-1:0] rd_node;
    logic [htsd_pkg::IDX_W-1:0]  len_value;

    assign tag_full = {tag_reg, byte_reg};
    assign nbits    = !last_reg ? 4'd8 : ((drop_reg >= 8'd8) ? 4'd0 : (4'd8 - drop_reg[3:0]));
    assign bit_val  = byte_reg[~bit_reg[2:0]];
    assign nxt      = !tree_valid_reg ? '0 : (bit_val ? right_q : left_q);
    assign cnt      = (nbytes_q > htsd_pkg::IDX_W'(htsd_pkg::MAX_SYMBOL_BYTES))
                      ? htsd_pkg::IDX_W'(htsd_pkg::MAX_SYMBOL_BYTES) : nbytes_q;
    assign parent   = stack_q[htsd_pkg::ENT_W-1:1];
    assign side     = stack_q[0];
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_node  = cmd.walk_step ? nxt : walk_reg;
    assign wr_addr  = htsd_pkg::STORE_AW'(build_reg) *
                      htsd_pkg::STORE_AW'(htsd_pkg::MAX_SYMBOL_BYTES)
                      + htsd_pkg::STORE_AW'(idx_reg);
    assign rd_addr  = htsd_pkg::STORE_AW'(walk_reg) *
                      htsd_pkg::STORE_AW'(htsd_pkg::MAX_SYMBOL_BYTES)
                      + htsd_pkg::STORE_AW'(idx_reg);
    assign len_value = sts.len_over ? htsd_pkg::IDX_W'(htsd_pkg::MAX_SYMBOL_BYTES)
                                    : byte_reg[htsd_pkg::IDX_W-1:0];

    always_comb
    begin
        if (tag_full == htsd_pkg::TAG_ABL)
            sts.tag_kind = htsd_pkg::TK_ABL;
        else if (tag_full == htsd_pkg::TAG_HMT)
            sts.tag_kind = htsd_pkg::TK_HMT;
        else if (tag_full == htsd_pkg::TAG_REM)
            sts.tag_kind = htsd_pkg::TK_REM;
        else if (tag_full == htsd_pkg::TAG_DAT)
            sts.tag_kind = htsd_pkg::TK_DAT;
        else
            sts.tag_kind = htsd_pkg::TK_OTHER;
        sts.byte_zero  = (byte_reg == 8'd0);
        sts.byte_b0    = byte_reg[0];
        sts.byte_b1    = byte_reg[1];
        sts.len_over   = (byte_reg > 8'(htsd_pkg::MAX_SYMBOL_BYTES));
        sts.byte_ws    = (byte_reg inside {8'h20, [8'h09:8'h0D]});
        sts.len_set    = len_set_reg;
        sts.drop_set   = drop_set_reg;
        sts.len_zero   = (len_reg == '0);
        sts.sym_done   = ((idx_reg + 1'b1) >= len_reg);
        sts.sp_zero    = (sp_reg == '0);
        sts.sp_full    = (sp_reg >= htsd_pkg::SP_W'(htsd_pkg::STACK_DEPTH));
        sts.count_full = (node_count_reg >= htsd_pkg::CNT_W'(htsd_pkg::NODES));
        sts.bits_done  = (bit_reg == nbits);
        sts.nxt_none   = (nxt == '0);
        sts.leaf       = (left_q == '0) && (right_q == '0);
        sts.leaf_done  = (idx_reg == cnt);
        sts.out_free   = out_free;
        sts.pend_valid = pend_valid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_set_reg    <= 1'b0;
            drop_set_reg   <= 1'b0;
            tree_valid_reg <= 1'b0;
            node_count_reg <= htsd_pkg::CNT_W'(1);
            sp_reg         <= '0;
            walk_reg       <= '0;
            build_reg      <= '0;
            idx_reg        <= '0;
            bit_reg        <= '0;
            tag_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tag_first)
                tag_reg <= {8'd0, byte_reg};
            if (cmd.tag_shift)
                tag_reg <= {tag_reg[7:0], byte_reg};
            if (cmd.set_len || cmd.len_default)
                len_set_reg <= 1'b1;
            if (cmd.set_drop || cmd.drop_default)
                drop_set_reg <= 1'b1;
            if (cmd.tree_start)
            begin
                tree_valid_reg <= 1'b1;
                node_count_reg <= htsd_pkg::CNT_W'(1);
                build_reg      <= '0;
                sp_reg         <= '0;
                walk_reg       <= '0;
            end
            if (cmd.push)
                sp_reg <= sp_reg + 1'b1;
            if (cmd.pop_rd)
                sp_reg <= sp_reg - 1'b1;
            if (cmd.sp_clear)
                sp_reg <= '0;
            if (cmd.new_node)
            begin
                build_reg      <= node_count_reg[htsd_pkg::NODE_W-1:0];
                node_count_reg <= node_count_reg + 1'b1;
            end
            if (cmd.set_leaf || cmd.idx_clear)
                idx_reg <= '0;
            if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.bit_clear)
                bit_reg <= '0;
            if (cmd.bit_next)
                bit_reg <= bit_reg + 1'b1;
            if (cmd.walk_step)
                walk_reg <= nxt;
            if (cmd.walk_root)
                walk_reg <= '0;

            // A word moving into the output register wins over one leaving it.
            if (cmd.flush || (cmd.emit && pend_valid_reg))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.emit)
                pend_valid_reg <= 1'b1;
            if (cmd.flush)
                pend_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
            last_reg <= final_byte;
        end
        if (cmd.set_len)
            len_reg <= len_value;
        if (cmd.len_default)
            len_reg <= htsd_pkg::IDX_W'(1);
        if (cmd.set_drop)
            drop_reg <= byte_reg;
        if (cmd.drop_default)
            drop_reg <= 8'd0;
        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                out_byte_reg   <= pend_byte_reg;
                out_end_reg    <= pend_end_reg;
                out_status_reg <= pend_status_reg;
                out_last_reg   <= 1'b0;
            end
            pend_byte_reg   <= cmd.emit_data ? store_q : 8'd0;
            pend_end_reg    <= cmd.emit_data && ((idx_reg + 1'b1) == cnt);
            pend_status_reg <= cmd.emit_code;
        end
        if (cmd.flush)
        begin
            out_byte_reg   <= pend_byte_reg;
            out_end_reg    <= pend_end_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    // Node table, split into link and count fields.
    always_ff @(posedge clk)
    begin
        if (cmd.tree_start)
        begin
            left_mem[0]   <= '0;
            right_mem[0]  <= '0;
            nbytes_mem[0] <= '0;
        end
        if (cmd.new_node)
        begin
            left_mem[node_count_reg[htsd_pkg::NODE_W-1:0]]   <= '0;
            right_mem[node_count_reg[htsd_pkg::NODE_W-1:0]]  <= '0;
            nbytes_mem[node_count_reg[htsd_pkg::NODE_W-1:0]] <= '0;
        end
        if (cmd.link && !side)
            left_mem[parent] <= build_reg;
        if (cmd.link && side)
            right_mem[parent] <= build_reg;
        if (cmd.set_leaf)
            nbytes_mem[build_reg] <= len_reg;
        if (cmd.set_inner)
            nbytes_mem[build_reg] <= '0;
        if (cmd.node_rd)
        begin
            left_q   <= left_mem[rd_node];
            right_q  <= right_mem[rd_node];
            nbytes_q <= nbytes_mem[rd_node];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sym_write)
            store_mem[wr_addr] <= byte_reg;
        if (cmd.sym_rd)
            store_q <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[sp_reg] <= {build_reg, cmd.push_side};
        if (cmd.pop_rd)
            stack_q <= stack_mem[sp_reg - 1'b1];
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign symbol_end = out_end_reg;
    assign run_last   = out_last_reg;
    assign status     = out_status_reg;

endmodule

@@ design/htsd_ctrl.sv @@
module htsd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  htsd_pkg::sts_t sts,
    output htsd_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        P_TAG0,
        P_TAG1,
        P_TAG2,
        P_ABL,
        P_REM,
        P_IND,
        P_SYM,
        P_DAT
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_HMT_INIT,
        S_DAT_INIT,
        S_PUSH_L,
        S_NEXT,
        S_POP,
        S_LINK,
        S_ABORT,
        S_WALK_RD,
        S_WALK_CHK,
        S_LEAF_CHK,
        S_SYM_RD,
        S_SYM_EMIT,
        S_END
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (phase_reg)
                    P_TAG0:
                    begin
                        cmd.tag_first = 1'b1;
                        phase_next    = P_TAG1;
                        state_next    = S_END;
                    end
                    P_TAG1:
                    begin
                        cmd.tag_shift = 1'b1;
                        phase_next    = P_TAG2;
                        state_next    = S_END;
                    end
                    P_TAG2:
                    begin
                        case (sts.tag_kind)
                            htsd_pkg::TK_ABL:
                            begin
                                phase_next = P_ABL;
                                state_next = S_END;
                            end
                            htsd_pkg::TK_REM:
                            begin
                                phase_next = P_REM;
                                state_next = S_END;
                            end
                            htsd_pkg::TK_HMT:
                            begin
                                if (sts.len_set)
                                    state_next = S_HMT_INIT;
                                else if (sts.out_free)
                                begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_code   = htsd_pkg::ST_DEFAULT;
                                    cmd.len_default = 1'b1;
                                    state_next      = S_HMT_INIT;
                                end
                            end
                            htsd_pkg::TK_DAT:
                            begin
                                if (sts.drop_set)
                                    state_next = S_DAT_INIT;
                                else if (sts.out_free)
                                begin
                                    cmd.emit         = 1'b1;
                                    cmd.emit_code    = htsd_pkg::ST_DEFAULT;
                                    cmd.drop_default = 1'b1;
                                    state_next       = S_DAT_INIT;
                                end
                            end
                            default:
                            begin
                                if (sts.out_free)
                                begin
                                    cmd.emit      = 1'b1;
                                    cmd.emit_code = htsd_pkg::ST_UNKNOWN;
                                    phase_next    = P_TAG0;
                                    state_next    = S_END;
                                end
                            end
                        endcase
                    end
                    P_ABL:
                    begin
                        if (!sts.len_over || sts.out_free)
                        begin
                            cmd.emit      = sts.len_over;
                            cmd.emit_code = htsd_pkg::ST_TREE_ERR;
                            cmd.set_len   = 1'b1;
                            phase_next    = P_TAG0;
                            state_next    = S_END;
                        end
                    end
                    P_REM:
                    begin
                        if (!sts.byte_ws)
                        begin
                            cmd.set_drop = 1'b1;
                            phase_next   = P_TAG0;
                        end
                        state_next = S_END;
                    end
                    P_IND:
                    begin
                        if (sts.byte_zero)
                        begin
                            cmd.set_leaf = 1'b1;
                            if (sts.len_zero)
                                state_next = S_NEXT;
                            else
                            begin
                                phase_next = P_SYM;
                                state_next = S_END;
                            end
                        end
                        else
                        begin
                            cmd.set_inner = 1'b1;
                            if (sts.byte_b0 && sts.sp_full)
                                state_next = S_ABORT;
                            else
                            begin
                                cmd.push      = sts.byte_b0;
                                cmd.push_side = 1'b1;
                                state_next    = S_PUSH_L;
                            end
                        end
                    end
                    P_SYM:
                    begin
                        cmd.sym_write = 1'b1;
                        cmd.idx_inc   = 1'b1;
                        state_next    = sts.sym_done ? S_NEXT : S_END;
                    end
                    P_DAT:
                    begin
                        cmd.bit_clear = 1'b1;
                        state_next    = S_WALK_RD;
                    end
                    default:
                    begin
                        phase_next = P_TAG0;
                        state_next = S_END;
                    end
                endcase
            end
            S_HMT_INIT:
            begin
                cmd.tree_start = 1'b1;
                phase_next     = P_IND;
                state_next     = S_END;
            end
            S_DAT_INIT:
            begin
                cmd.walk_root = 1'b1;
                phase_next    = P_DAT;
                state_next    = S_END;
            end
            S_PUSH_L:
            begin
                if (sts.byte_b1 && sts.sp_full)
                    state_next = S_ABORT;
                else
                begin
                    cmd.push   = sts.byte_b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (sts.sp_zero)
                begin
                    phase_next = P_TAG0;
                    state_next = S_END;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sts.count_full)
                    state_next = S_ABORT;
                else
                begin
                    cmd.new_node = 1'b1;
                    state_next   = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                phase_next = P_IND;
                state_next = S_END;
            end
            S_ABORT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = htsd_pkg::ST_TREE_ERR;
                    cmd.sp_clear  = 1'b1;
                    phase_next    = P_TAG0;
                    state_next    = S_END;
                end
            end
            S_WALK_RD:
            begin
                if (sts.bits_done)
                    state_next = S_END;
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (sts.nxt_none)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = htsd_pkg::ST_BAD_CODE;
                        cmd.walk_root = 1'b1;
                        cmd.bit_next  = 1'b1;
                        state_next    = S_WALK_RD;
                    end
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.node_rd   = 1'b1;
                    state_next    = S_LEAF_CHK;
                end
            end
            S_LEAF_CHK:
            begin
                if (sts.leaf)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_SYM_RD;
                end
                else
                begin
                    cmd.bit_next = 1'b1;
                    state_next   = S_WALK_RD;
                end
            end
            S_SYM_RD:
            begin
                if (sts.leaf_done)
                begin
                    cmd.walk_root = 1'b1;
                    cmd.bit_next  = 1'b1;
                    state_next    = S_WALK_RD;
                end
                else
                begin
                    cmd.sym_rd = 1'b1;
                    state_next = S_SYM_EMIT;
                end
            end
            S_SYM_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.emit_code = htsd_pkg::ST_DATA;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_SYM_RD;
                end
            end
            S_END:
            begin
                if (!sts.pend_valid)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_TAG0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

@@ design/huffman_tree_stream_decoder.sv @@
// Bytes are taken one at a time. A data byte is decoded one code bit at a time from
// the current node: a bad code emits an error word and restarts at the root, an inner
// node steps on, and a leaf emits its symbol bytes one by one and returns to the root.
// Latency: a byte's last result word is offered in the cycle the next byte can be taken.
// Reset (rst_n low, asynchronous) clears the controller, flags, counters and word valids;
// the node table and symbol store are not cleared and need no clearing pass.
`include "assert_macros.svh"

module huffman_tree_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       symbol_end,
    output logic       run_last,
    output logic [2:0] status
);

    // The controller walks the parse phases and the bit-by-bit tree descent; the
    // datapath owns the node table, symbol store, pending-child stack and the two
    // result registers. One result word is held back as pending until the next
    // word or the end of the byte shows whether it is the last one of its byte,
    // so run_last can be set on it.
    htsd_pkg::cmd_t cmd;
    htsd_pkg::sts_t sts;

    htsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_valid),
        .in_stall (byte_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    htsd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .out_stall  (result_stall),
        .out_valid  (result_valid),
        .out_byte   (out_byte),
        .symbol_end (symbol_end),
        .run_last   (run_last),
        .status     (status)
    );

    // A word is only pushed toward the output register when there is room there.
    `AST_IMPL(a_emit_room, cmd.emit || cmd.flush, sts.out_free)
    // A flush always has a pending word to move.
    `AST_IMPL(a_flush_pend, cmd.flush, sts.pend_valid)
    // While taking a new byte, nothing from the previous byte is held back.
    `AST_IMPL(a_idle_clean, !byte_stall, !sts.pend_valid)
    // An accepted byte is processed before another one is taken.
    `AST_NEXT(a_one_byte, byte_valid && !byte_stall, byte_stall)

endmodule
